>>> hw/rtl/pwo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_pkg
// Shared types, register codes and constants of the PolyBLEP oscillator.
// ----------------------------------------------------------------------------
package pwo_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    // Quotient bits of x = u * 2^30 / dt, with u < dt
    localparam int DIV_BITS = 30;
    localparam int DIV_CW   = $clog2(DIV_BITS);

    // One in Q2.30, held in the 34-bit signed working word
    localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

    // Half pi in Q30, used to build the sine table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Register reset values
    localparam logic [31:0] RST_INCREMENT = 32'd42852281;
    localparam logic [15:0] RST_GAIN      = 16'd16384;
    localparam logic [15:0] RST_DUTY      = 16'd32768;
    localparam logic [31:0] RST_START     = 32'd0;
    localparam logic [31:0] NYQUIST_INC   = 32'h8000_0000;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAW      = 2'd3
    } t_shape;

    typedef enum logic [2:0] {
        REG_SHAPE     = 3'd0,
        REG_INCREMENT = 3'd1,
        REG_GAIN      = 3'd2,
        REG_DUTY      = 3'd3,
        REG_START     = 3'd4,
        REG_BLEP      = 3'd5
    } t_reg_idx;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic sine_rd;
        logic sine_mul;
        logic sine_fin;
        logic bsel;
        logic div_step;
        logic blep_sq;
        logic blep_acc;
        logic pass_inc;
        logic gain;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_sine;
        logic need_blep;
        logic blep_hit;
        logic div_last;
        logic last_pass;
        logic out_free;
    } t_status;

endpackage

>>> hw/rtl/pwo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_div
// Restoring divider, one quotient bit per cycle: q = floor(num * 2^30 / den)
// for num < den.
// ----------------------------------------------------------------------------
module pwo_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_step,
    input  logic [31:0]                  i_num,
    input  logic [31:0]                  i_den,
    output logic [pwo_pkg::DIV_BITS-1:0] o_quo,
    output logic                         o_last
);
    import pwo_pkg::*;

    logic [32:0]         r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic [DIV_CW-1:0]   r_cnt;
    logic [32:0]         w_rem2;
    logic                w_ge;

    // Shift the remainder and try one subtract
    assign w_rem2 = {r_rem[31:0], 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, i_den};

    // Load the operand, then develop one bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_quo <= '0;
        end else if (i_step) begin
            r_rem <= w_ge ? (w_rem2 - {1'b0, i_den}) : w_rem2;
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    // Count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quo  = r_quo;
    assign o_last = r_cnt == DIV_CW'(DIV_BITS - 1);

    // The partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_rem < {1'b0, i_den}))
        else $error("divider remainder out of range");

    // Steps never run past the quotient width
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (r_cnt <= DIV_CW'(DIV_BITS - 1)))
        else $error("divider stepped past last bit");

endmodule

>>> hw/rtl/pwo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_ctrl
// Sequencer of the oscillator: steps the datapath through shape, PolyBLEP
// passes, gain and output.
// ----------------------------------------------------------------------------
module pwo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pwo_pkg::t_status  i_status,
    output pwo_pkg::t_cmd     o_cmd
);
    import pwo_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PREP  = 12'b0000_0000_0010,
        S_SRD   = 12'b0000_0000_0100,
        S_SMUL  = 12'b0000_0000_1000,
        S_SFIN  = 12'b0000_0001_0000,
        S_BSEL  = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_SQ    = 12'b0000_1000_0000,
        S_ACC   = 12'b0001_0000_0000,
        S_BNEXT = 12'b0010_0000_0000,
        S_GAIN  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                if (i_status.is_sine) begin
                    n_state = S_SRD;
                end else if (i_status.need_blep) begin
                    n_state = S_BSEL;
                end else begin
                    n_state = S_GAIN;
                end
            end
            S_SRD: begin
                w_cmd.sine_rd = 1'b1;
                n_state       = S_SMUL;
            end
            S_SMUL: begin
                w_cmd.sine_mul = 1'b1;
                n_state        = S_SFIN;
            end
            S_SFIN: begin
                w_cmd.sine_fin = 1'b1;
                n_state        = S_GAIN;
            end
            S_BSEL: begin
                w_cmd.bsel = 1'b1;
                n_state    = i_status.blep_hit ? S_DIV : S_BNEXT;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                w_cmd.blep_sq = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                w_cmd.blep_acc = 1'b1;
                n_state        = S_BNEXT;
            end
            S_BNEXT: begin
                if (i_status.last_pass) begin
                    n_state = S_GAIN;
                end else begin
                    w_cmd.pass_inc = 1'b1;
                    n_state        = S_BSEL;
                end
            end
            S_GAIN: begin
                w_cmd.gain = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = r_state == S_IDLE;

    // A captured transaction always starts preparation next
    a_capture_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> (r_state == S_PREP))
        else $error("capture not followed by prep");

    // Divide steps only follow a divider start or another step
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ($past(r_state) == S_BSEL || $past(r_state) == S_DIV))
        else $error("divide entered without select");

endmodule

>>> hw/rtl/pwo_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwo_dpath
// Datapath: registers, phase accumulator, sine table, shape logic,
// PolyBLEP arithmetic, gain multiply, saturation and output register.
// ----------------------------------------------------------------------------
module pwo_dpath #(
    parameter int TABLE_DEPTH = pwo_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = pwo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          i_load_phase,
    input  pwo_pkg::t_cmd                 i_cmd,
    output pwo_pkg::t_status              o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);
    import pwo_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = 32 + $clog2(TABLE_DEPTH + 1);
    localparam int SH = 46 - SAMPLE_BITS;
    localparam logic signed [50:0] S_HI = (51'sd1 <<< (SAMPLE_BITS - 1)) - 51'sd1;
    localparam logic signed [50:0] S_LO = -(51'sd1 <<< (SAMPLE_BITS - 1));

    // Quarter-wave Taylor sine, mirrored, rounded to Q1.15
    function automatic logic signed [15:0] rom_entry(input int unsigned idx);
        logic [63:0]        p;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        mag;
        logic               neg;
        p    = ({32'd0, idx} << 32) / TABLE_DEPTH;
        neg  = p[31];
        p    = p & 64'h7FFF_FFFF;
        if (p > 64'h4000_0000) begin
            p = 64'h8000_0000 - p;
        end
        x    = (p * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        mag = (unsigned'(sum) + 64'd16384) >> 15;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return neg ? -signed'(mag[15:0]) : signed'(mag[15:0]);
    endfunction

    // Configuration registers
    t_shape      r_shape;
    logic [31:0] r_dt;
    logic [15:0] r_gain;
    logic [15:0] r_duty;
    logic [31:0] r_start;
    logic        r_blep;

    // Working registers
    logic [31:0]          r_phase;
    logic [31:0]          r_t;
    logic signed [33:0]   r_y;
    logic [AW-1:0]        r_i0;
    logic [AW-1:0]        r_i1;
    logic [31:0]          r_frac;
    logic signed [15:0]   r_a;
    logic signed [15:0]   r_b;
    logic signed [50:0]   r_prod;
    logic                 r_pass;
    logic                 r_neg;
    logic [DIV_BITS-1:0]  r_sq;
    logic                 r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    logic signed [15:0]   w_rom [TABLE_DEPTH];
    logic [PW-1:0]        w_pos;
    logic [AW-1:0]        w_i0;
    logic [31:0]          w_duty;
    logic [32:0]          w_tri_mag;
    logic signed [33:0]   w_base;
    logic [31:0]          w_u;
    logic                 w_case1;
    logic                 w_case2;
    logic [31:0]          w_num;
    logic [DIV_BITS-1:0]  w_quo;
    logic                 w_div_last;
    logic [59:0]          w_sq_full;
    logic signed [33:0]   w_b;
    logic                 w_sub;
    logic signed [16:0]   w_diff;
    logic signed [32:0]   w_frac_s;
    logic signed [16:0]   w_gain_s;
    logic signed [50:0]   w_scaled;
    logic signed [SAMPLE_BITS-1:0] w_sat;
    logic                 w_out_free;

    // Build the sine table as constant logic
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        localparam logic signed [15:0] ROM_VAL = rom_entry(g);
        assign w_rom[g] = ROM_VAL;
    end

    // Write configuration registers; clamp the increment at Nyquist
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_SINE;
            r_dt    <= RST_INCREMENT;
            r_gain  <= RST_GAIN;
            r_duty  <= RST_DUTY;
            r_start <= RST_START;
            r_blep  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SHAPE:     r_shape <= t_shape'(i_cfg_wdata[1:0]);
                REG_INCREMENT: r_dt    <= (i_cfg_wdata > NYQUIST_INC) ? NYQUIST_INC
                                                                       : i_cfg_wdata;
                REG_GAIN:      r_gain  <= i_cfg_wdata[15:0];
                REG_DUTY:      r_duty  <= i_cfg_wdata[15:0];
                REG_START:     r_start <= i_cfg_wdata;
                REG_BLEP:      r_blep  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Table position of the phase
    assign w_pos = PW'(r_t) * PW'(TABLE_DEPTH);
    assign w_i0  = w_pos[32 +: AW];

    // Naive shapes in Q2.30
    assign w_duty    = {r_duty, 16'd0};
    assign w_tri_mag = r_t[31] ? {2'b00, r_t[30:0]} : (33'h0_8000_0000 - {1'b0, r_t});
    always_comb begin
        case (r_shape)
            SHAPE_SQUARE:   w_base = (r_t < w_duty) ? ONE_Q30 : -ONE_Q30;
            SHAPE_TRIANGLE: w_base = signed'({1'b0, w_tri_mag}) - ONE_Q30;
            SHAPE_SAW:      w_base = signed'({3'b000, r_t[31:1]}) - ONE_Q30;
            default:        w_base = '0;
        endcase
    end

    // PolyBLEP argument and region: just after or just before the edge
    assign w_u     = r_pass ? (r_t - w_duty) : r_t;
    assign w_case1 = w_u < r_dt;
    assign w_case2 = {1'b0, w_u} > (33'h1_0000_0000 - {1'b0, r_dt});
    assign w_num   = w_case1 ? w_u : 32'(33'h1_0000_0000 - {1'b0, w_u});

    pwo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.bsel && (w_case1 || w_case2)),
        .i_step  (i_cmd.div_step),
        .i_num   (w_num),
        .i_den   (r_dt),
        .o_quo   (w_quo),
        .o_last  (w_div_last)
    );

    // Correction term b = 2x - x^2 - 1, negated in the trailing region
    assign w_sq_full = 60'(w_quo) * 60'(w_quo);
    assign w_b       = signed'({3'b000, w_quo, 1'b0}) - signed'({4'b0000, r_sq}) - ONE_Q30;
    assign w_sub     = (r_shape == SHAPE_SAW) || r_pass;

    // Multiplier operands
    assign w_diff   = 17'(r_b) - 17'(r_a);
    assign w_frac_s = signed'({1'b0, r_frac});
    assign w_gain_s = signed'({1'b0, r_gain});

    // Floor-scale and saturate the sample
    assign w_scaled = r_prod >>> SH;
    assign w_sat    = (w_scaled > S_HI) ? S_HI[SAMPLE_BITS-1:0] :
                      (w_scaled < S_LO) ? S_LO[SAMPLE_BITS-1:0] :
                                          w_scaled[SAMPLE_BITS-1:0];

    // Phase accumulator: load on request, advance after the shape is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.prep) begin
            r_phase <= r_t + r_dt;
        end
    end

    // Sequence the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_t <= i_load_phase ? r_start : r_phase;
        end
        if (i_cmd.prep) begin
            r_y    <= w_base;
            r_i0   <= w_i0;
            r_i1   <= (w_i0 == AW'(TABLE_DEPTH - 1)) ? '0 : w_i0 + 1'b1;
            r_frac <= w_pos[31:0];
            r_pass <= 1'b0;
        end
        if (i_cmd.sine_rd) begin
            r_a <= w_rom[r_i0];
            r_b <= w_rom[r_i1];
        end
        if (i_cmd.sine_mul) begin
            r_prod <= 51'(w_diff) * 51'(w_frac_s);
        end
        if (i_cmd.sine_fin) begin
            r_y <= signed'({{3{r_a[15]}}, r_a, 15'd0}) + 34'(r_prod >>> 17);
        end
        if (i_cmd.bsel) begin
            r_neg <= !w_case1;
        end
        if (i_cmd.blep_sq) begin
            r_sq <= w_sq_full[59:30];
        end
        if (i_cmd.blep_acc) begin
            r_y <= (r_neg ^ w_sub) ? (r_y - w_b) : (r_y + w_b);
        end
        if (i_cmd.pass_inc) begin
            r_pass <= 1'b1;
        end
        if (i_cmd.gain) begin
            r_prod <= 51'(r_y) * 51'(w_gain_s);
        end
        if (i_cmd.out_load) begin
            r_sample <= w_sat;
        end
    end

    // Output register: hold until the transaction is taken
    assign w_out_free = !r_out_valid || i_out_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status to the controller
    assign o_status.is_sine   = r_shape == SHAPE_SINE;
    assign o_status.need_blep = r_blep && (r_dt != '0) && (r_shape inside {SHAPE_SQUARE, SHAPE_SAW});
    assign o_status.blep_hit  = w_case1 || w_case2;
    assign o_status.div_last  = w_div_last;
    assign o_status.last_pass = (r_shape == SHAPE_SAW) || r_pass;
    assign o_status.out_free  = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample;

    // A new sample never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output overwritten");

endmodule

>>> hw/rtl/polyblep_wave_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_wave_oscillator
// Phase-accumulator oscillator: sine, PolyBLEP square, triangle and PolyBLEP
// sawtooth, scaled by a gain and saturated, one sample per transaction.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready   | i_load_phase
//  output   | o_out_valid / i_out_ready | o_sample_out
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
//  One transaction at a time. Triangle passes from capture to gain and
//  output; sine adds a table read, an interpolating multiply and a finish;
//  each PolyBLEP hit on square or sawtooth adds divider steps, square, add.
//  Reset is synchronous, active low, and needs no clearing pass.
//  A stalled output holds the sample; the next input is taken meanwhile.
// ----------------------------------------------------------------------------
module polyblep_wave_oscillator #(
    parameter int TABLE_DEPTH = pwo_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = pwo_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_load_phase,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);
    import pwo_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pwo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pwo_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_load_phase (i_load_phase),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

endmodule

>>> dv/polyblep_wave_oscillator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_wave_oscillator_tb
// Self-checking bench for the PolyBLEP oscillator. A directed table covers
// the shape extremes, gain and duty corners, zero and over-Nyquist increments
// and both edge corrections. Random phases with random register settings
// follow. Each sample is checked against a row value or bit-exact predictor
// of the phase accumulator, sine table, PolyBLEP terms, gain and saturation.
// ----------------------------------------------------------------------------
module polyblep_wave_oscillator_tb;
    import pwo_pkg::*;

    localparam int          DEPTH       = 256;
    localparam int          SBITS       = 16;
    localparam int          DRAIN_WAIT  = 100;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  REG_SPARE_A = 3'd6;
    localparam logic [2:0]  REG_SPARE_B = 3'd7;
    localparam longint      ONE         = 64'sd1 << 30;
    localparam longint      HALF_PI     = 64'sd1686629713;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [2:0]              i_cfg_index;
    logic [31:0]             i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_load_phase;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [SBITS-1:0] o_sample_out;

    polyblep_wave_oscillator uut (.*);

    // Predictor state
    int unsigned  sine_rom [DEPTH];
    logic [31:0]  acc_phase;
    t_shape       m_shape;
    logic [31:0]  m_inc;
    logic [15:0]  m_gain;
    logic [15:0]  m_duty;
    logic [31:0]  m_start;
    logic         m_blep;

    logic signed [SBITS-1:0] sample_q [$];
    int  errors;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_go;
    longint unsigned cycles;

    typedef struct {
        bit          prog;
        t_shape      shape;
        logic [31:0] inc;
        logic [15:0] gain;
        logic [15:0] duty;
        logic [31:0] start;
        logic        blep;
        logic        load;
        bit          chk;
        int          expv;
    } t_row;

    t_row rows [] = '{
        '{0, SHAPE_SINE,     32'd0,        16'd0,     16'd0,     32'd0,        1'b1, 1'b0, 1, 0},
        '{1, SHAPE_TRIANGLE, 32'd0,        16'hFFFF,  16'd0,     32'd0,        1'b1, 1'b1, 1, 32767},
        '{1, SHAPE_TRIANGLE, 32'd0,        16'hFFFF,  16'd0,     32'h8000_0000, 1'b1, 1'b1, 1, -32768},
        '{1, SHAPE_SAW,      32'd0,        16'h8000,  16'd0,     32'd0,        1'b0, 1'b1, 1, -32768},
        '{1, SHAPE_TRIANGLE, 32'h1234_5678, 16'd0,    16'd0,     32'h0BAD_F00D, 1'b1, 1'b1, 1, 0},
        '{1, SHAPE_SINE,     32'h1000_0000, 16'h8000, 16'd0,     32'd0,        1'b1, 1'b1, 0, 0},
        '{0, SHAPE_SINE,     32'd0,        16'd0,     16'd0,     32'd0,        1'b0, 1'b0, 0, 0},
        '{1, SHAPE_SINE,     32'h0123_4567, 16'hFFFF, 16'd0,     32'hFFFF_FFFF, 1'b1, 1'b1, 0, 0},
        '{1, SHAPE_SINE,     32'd0,        16'hFFFF,  16'd0,     32'h4000_0000, 1'b1, 1'b1, 0, 0},
        '{1, SHAPE_SQUARE,   32'h0100_0000, 16'h8000, 16'd0,     32'd0,        1'b1, 1'b1, 0, 0},
        '{0, SHAPE_SINE,     32'd0,        16'd0,     16'd0,     32'd0,        1'b0, 1'b0, 0, 0},
        '{1, SHAPE_SQUARE,   32'h0400_0000, 16'h7FFF, 16'hFFFF,  32'hFFFF_0000, 1'b1, 1'b1, 0, 0},
        '{1, SHAPE_SQUARE,   32'h0400_0000, 16'h7FFF, 16'h8000,  32'h7FFF_FFFF, 1'b0, 1'b1, 0, 0},
        '{1, SHAPE_SQUARE,   32'hFFFF_FFFF, 16'h6000, 16'h4000,  32'd0,        1'b1, 1'b1, 0, 0},
        '{0, SHAPE_SINE,     32'd0,        16'd0,     16'd0,     32'd0,        1'b0, 1'b0, 0, 0},
        '{1, SHAPE_SQUARE,   32'd0,        16'h8000,  16'h8000,  32'h1000_0000, 1'b1, 1'b1, 0, 0},
        '{1, SHAPE_SAW,      32'h0400_0000, 16'h8000, 16'd0,     32'hFFFF_FF00, 1'b1, 1'b1, 0, 0},
        '{0, SHAPE_SINE,     32'd0,        16'd0,     16'd0,     32'd0,        1'b0, 1'b0, 0, 0},
        '{1, SHAPE_SAW,      32'h0400_0000, 16'hFFFF, 16'd0,     32'h0000_0100, 1'b1, 1'b1, 0, 0},
        '{1, SHAPE_SAW,      32'h8000_0001, 16'hFFFF, 16'd0,     32'h8000_0000, 1'b1, 1'b1, 0, 0}
    };

    // Build one quarter-mirrored sine entry in Q1.15
    function automatic int rom_value(int unsigned idx);
        longint unsigned p, x, x2, term;
        longint          sum;
        int              mag;
        bit              neg;
        p   = ((longint'(idx) << 32) / DEPTH) & 64'hFFFF_FFFF;
        neg = p[31];
        p   = p & 64'h7FFF_FFFF;
        if (p > 64'h4000_0000)
            p = 64'h8000_0000 - p;
        x    = (p * HALF_PI) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum -= term;
            else
                sum += term;
        end
        if (sum < 0)
            sum = 0;
        mag = int'((sum + 16384) >>> 15);
        if (mag > 32767)
            mag = 32767;
        return neg ? -mag : mag;
    endfunction

    // PolyBLEP residual in Q30 around a discontinuity at phase zero
    function automatic longint blep_term(logic [31:0] t, logic [31:0] dt);
        longint unsigned x;
        if (dt == 0)
            return 0;
        if (t < dt) begin
            x = (longint'(t) << 30) / longint'(dt);
            return longint'(2 * x) - longint'((x * x) >> 30) - ONE;
        end
        if (longint'(t) > (64'sd1 << 32) - longint'(dt)) begin
            x = (((64'sd1 << 32) - longint'(t)) << 30) / longint'(dt);
            return longint'((x * x) >> 30) - longint'(2 * x) + ONE;
        end
        return 0;
    endfunction

    // Mirror one register write, with masking and Nyquist clamp
    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_SHAPE:     m_shape = t_shape'(val[1:0]);
            REG_INCREMENT: m_inc   = (val > NYQUIST_INC) ? NYQUIST_INC : val;
            REG_GAIN:      m_gain  = val[15:0];
            REG_DUTY:      m_duty  = val[15:0];
            REG_START:     m_start = val;
            REG_BLEP:      m_blep  = val[0];
            default: ;
        endcase
    endfunction

    // Compute the next oscillator sample and advance the phase
    function automatic logic signed [SBITS-1:0] next_sample(logic load);
        logic [31:0]     t, duty32, i0, i1;
        longint unsigned pos, frac;
        longint          y, s, a, b;
        bit              corr;
        if (load)
            acc_phase = m_start;
        t      = acc_phase;
        duty32 = {m_duty, 16'd0};
        corr   = m_blep && (m_inc != 0);
        case (m_shape)
            SHAPE_SINE: begin
                pos  = longint'(t) * DEPTH;
                i0   = 32'((pos >> 32) % DEPTH);
                i1   = (i0 + 1) % DEPTH;
                frac = pos & 64'hFFFF_FFFF;
                a    = int'(sine_rom[i0]);
                b    = int'(sine_rom[i1]);
                y    = a * 32768 + (((b - a) * longint'(frac)) >>> 17);
            end
            SHAPE_SQUARE: begin
                y = (t < duty32) ? ONE : -ONE;
                if (corr)
                    y = y + blep_term(t, m_inc) - blep_term(t - duty32, m_inc);
            end
            SHAPE_TRIANGLE: begin
                y = (t >= 32'h8000_0000) ? longint'(t - 32'h8000_0000)
                                        : longint'(32'h8000_0000 - t);
                y -= ONE;
            end
            default: begin
                y = longint'(t >> 1) - ONE;
                if (corr)
                    y -= blep_term(t, m_inc);
            end
        endcase
        acc_phase = t + m_inc;
        s = (y * longint'(m_gain)) >>> (46 - SBITS);
        if (s > 32767)
            s = 32767;
        else if (s < -32768)
            s = -32768;
        return s[SBITS-1:0];
    endfunction

    task automatic report(string msg);
        $display("tb: mismatch: %s", msg);
        errors++;
    endtask

    // Clock and cycle limit
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Accept samples, check them and drive ready with idles and one long hold
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (sample_q.size() == 0)
                    report($sformatf("unexpected sample %0d", o_sample_out));
                else if (o_sample_out !== sample_q[0])
                    report($sformatf("sample got %0d want %0d",
                                     o_sample_out, sample_q[0]));
                if (sample_q.size() != 0)
                    void'(sample_q.pop_front());
            end
            if (hold_go) begin
                hold_go   = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Write one register, leaving the enable high for a following write
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic program_regs(t_shape sh, logic [31:0] inc, logic [15:0] gain,
                                logic [15:0] duty, logic [31:0] start, logic blep);
        cfg_write(REG_SHAPE, 32'({$urandom, sh}));
        cfg_write(REG_INCREMENT, inc);
        cfg_write(REG_GAIN, {16'($urandom_range(65535)), gain});
        cfg_write(REG_DUTY, {16'($urandom_range(65535)), duty});
        cfg_write(REG_START, start);
        cfg_write(REG_BLEP, 32'({$urandom, blep}));
        cfg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one transaction; valid stays high after acceptance
    task automatic send(logic load, bit chk, int expv);
        logic signed [SBITS-1:0] pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_load_phase <= load;
        do @(posedge i_clk); while (!o_in_ready);
        pred = next_sample(load);
        sample_q.push_back(chk ? expv[SBITS-1:0] : pred);
    endtask

    // Drop valid and wait until every sample has been delivered
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] inc;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_wdata  <= '0;
        i_in_valid   <= 1'b0;
        i_load_phase <= 1'b0;
        i_out_ready  <= 1'b0;
        errors       = 0;
        cycles       = 0;
        hold_go      = 0;
        tx_idle_pct  = 28;
        rx_idle_pct  = 28;
        for (int i = 0; i < DEPTH; i++)
            sine_rom[i] = rom_value(i);
        acc_phase = '0;
        m_shape   = SHAPE_SINE;
        m_inc     = RST_INCREMENT;
        m_gain    = RST_GAIN;
        m_duty    = RST_DUTY;
        m_start   = RST_START;
        m_blep    = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (rows[r]) begin
            if (rows[r].prog) begin
                drain();
                program_regs(rows[r].shape, rows[r].inc, rows[r].gain,
                             rows[r].duty, rows[r].start, rows[r].blep);
            end
            send(rows[r].load, rows[r].chk, rows[r].expv);
        end

        // Random phases; one without idles, one with a long receiver hold
        for (int ph = 0; ph < 14; ph++) begin
            drain();
            case ($urandom_range(3))
                0:       inc = $urandom;
                1:       inc = $urandom_range(32'h0100_0000);
                2:       inc = $urandom_range(32'h2000_0000, 32'h0001_0000);
                default: inc = $urandom_range(1) ? 32'd0 : 32'h8000_0000;
            endcase
            program_regs(t_shape'($urandom_range(3)), inc, 16'($urandom_range(65535)),
                         16'($urandom_range(65535)), $urandom, $urandom_range(3) != 0);
            tx_idle_pct = (ph == 4) ? 0 : 28;
            rx_idle_pct = (ph == 4) ? 0 : 28;
            if (ph == 7)
                hold_go = 1;
            for (int n = 0; n < 42; n++)
                send($urandom_range(9) == 0, 0, 0);
        end
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pwo_pkg.sv
hw/rtl/pwo_div.sv
hw/rtl/pwo_ctrl.sv
hw/rtl/pwo_dpath.sv
hw/rtl/polyblep_wave_oscillator.sv
dv/polyblep_wave_oscillator_tb.sv
